// File: src/bsmalu_pkg.sv
// Shared types, constants and packed-BCD helper functions for the decimal ALU.
// No dependencies; every other file in src imports this package.
package bsmalu_pkg;

    localparam int MAX_DIGITS = 16;
    localparam int DW         = 4 * MAX_DIGITS;
    localparam int BW         = DW + 4;
    localparam int CW         = 11;
    localparam int CYW        = 8;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_SUB = 2'd1;
    localparam logic [1:0] CMD_MUL = 2'd2;
    localparam logic [1:0] CMD_DIV = 2'd3;

    localparam logic [3:0]  DIGIT_MAX = 4'd9;
    localparam logic [12:0] RECIP10   = 13'd6554;
    localparam int          RECIP_SH  = 16;

    typedef logic [BW-1:0] t_bcdw;
    typedef logic [9:0][BW-1:0] t_mults;

    localparam t_bcdw SIXES = {(BW/4){4'h6}};
    localparam t_bcdw NINES = {(BW/4){4'h9}};

    typedef struct packed {
        logic [1:0]    cmd;
        logic [DW-1:0] operand_a;
        logic          a_negative;
        logic [DW-1:0] operand_b;
        logic          b_negative;
    } t_in;

    typedef struct packed {
        logic [DW-1:0] result_value;
        logic          result_negative;
        logic          overflow;
        logic          divide_by_zero;
        logic          a_greater;
        logic          a_equal;
    } t_out;

    function automatic t_bcdw bcd_add(input t_bcdw a, input t_bcdw b, input logic cin);
        logic [BW:0] s1;
        logic [BW:0] s2;
        logic [BW:0] cv;
        t_bcdw       corr;
        s1   = {1'b0, a} + {1'b0, SIXES};
        s2   = s1 + {1'b0, b} + {{BW{1'b0}}, cin};
        cv   = s2 ^ s1 ^ {1'b0, b};
        corr = '0;
        for (int i = 0; i < BW/4; i++) begin
            if (!cv[4*i+4]) begin
                corr[4*i +: 4] = 4'd6;
            end
        end
        return s2[BW-1:0] - corr;
    endfunction

    function automatic t_bcdw bcd_sub(input t_bcdw a, input t_bcdw b);
        return bcd_add(a, NINES - b, 1'b1);
    endfunction

endpackage

// File: src/bsmalu_mul.sv
// Pipelined decimal multiplier: digit-column accumulation, then carry normalization.
// Advances only on i_en. Depends on bsmalu_pkg.
module bsmalu_mul #(
    parameter int NUM_DIGITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [bsmalu_pkg::DW-1:0] i_ma,
    input  logic [bsmalu_pkg::DW-1:0] i_mb,
    output logic [bsmalu_pkg::DW-1:0] o_mag,
    output logic                   o_ovf
);
    import bsmalu_pkg::*;

    localparam int N = NUM_DIGITS;

    logic [DW-1:0]  r_ma  [N];
    logic [DW-1:0]  r_mb  [N];
    logic           r_hi  [N];
    logic [CW-1:0]  r_col [N][N];

    logic [CW-1:0]  r_nc  [N][N];
    logic [CYW-1:0] r_cy  [N];
    logic [DW-1:0]  r_dg  [N];
    logic           r_nh  [N];

    for (genvar j = 0; j < N; j++) begin : g_acc
        logic [DW-1:0] a_in;
        logic [DW-1:0] b_in;
        logic          h_in;
        logic [CW-1:0] c_in  [N];
        logic [CW-1:0] n_col [N];

        if (j == 0) begin : g_first
            always_comb begin
                a_in = i_ma;
                b_in = i_mb;
                h_in = 1'b0;
                for (int x = 0; x < N; x++) begin
                    c_in[x] = '0;
                    for (int y = 0; y < N; y++) begin
                        if (x + y >= N && i_ma[4*x +: 4] != 4'd0 && i_mb[4*y +: 4] != 4'd0) begin
                            h_in = 1'b1;
                        end
                    end
                end
            end
        end else begin : g_next
            always_comb begin
                a_in = r_ma[j-1];
                b_in = r_mb[j-1];
                h_in = r_hi[j-1];
                for (int x = 0; x < N; x++) begin
                    c_in[x] = r_col[j-1][x];
                end
            end
        end

        always_comb begin
            for (int k = 0; k < N; k++) begin
                n_col[k] = c_in[k];
            end
            for (int k = j; k < N; k++) begin
                n_col[k] = c_in[k]
                         + CW'({4'd0, a_in[4*(k-j) +: 4]} * {4'd0, b_in[4*j +: 4]});
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ma[j] <= a_in;
                r_mb[j] <= b_in;
                r_hi[j] <= h_in;
                for (int k = 0; k < N; k++) begin
                    r_col[j][k] <= n_col[k];
                end
            end
        end
    end

    for (genvar t = 0; t < N; t++) begin : g_norm
        logic [CW-1:0]  col [N];
        logic [CYW-1:0] cy;
        logic [DW-1:0]  dg;
        logic [DW-1:0]  n_dg;
        logic           hi;
        logic [CW-1:0]  v;
        logic [23:0]    prod;
        logic [CYW-1:0] q;
        logic [CW-1:0]  rem;

        if (t == 0) begin : g_first
            always_comb begin
                for (int k = 0; k < N; k++) begin
                    col[k] = r_col[N-1][k];
                end
                cy = '0;
                dg = '0;
                hi = r_hi[N-1];
            end
        end else begin : g_next
            always_comb begin
                for (int k = 0; k < N; k++) begin
                    col[k] = r_nc[t-1][k];
                end
                cy = r_cy[t-1];
                dg = r_dg[t-1];
                hi = r_nh[t-1];
            end
        end

        always_comb begin
            v    = col[t] + CW'(cy);
            prod = {13'd0, v} * {11'd0, RECIP10};
            q    = CYW'(prod >> RECIP_SH);
            rem  = v - CW'({3'd0, q} * 11'd10);
            n_dg = dg;
            n_dg[4*t +: 4] = rem[3:0];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int k = 0; k < N; k++) begin
                    r_nc[t][k] <= col[k];
                end
                r_cy[t] <= q;
                r_dg[t] <= n_dg;
                r_nh[t] <= hi;
            end
        end
    end

    assign o_mag = r_dg[N-1];
    assign o_ovf = r_nh[N-1] | (r_cy[N-1] != '0);

endmodule

// File: src/bsmalu_div.sv
// Pipelined decimal long divider on magnitudes: divisor multiples, then one
// quotient digit per two stages. Depends on bsmalu_pkg.
module bsmalu_div #(
    parameter int NUM_DIGITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [bsmalu_pkg::DW-1:0] i_ma,
    input  logic [bsmalu_pkg::DW-1:0] i_mb,
    output logic [bsmalu_pkg::DW-1:0] o_quot
);
    import bsmalu_pkg::*;

    localparam int N = NUM_DIGITS;

    t_mults        r_pm [4];
    t_mults        n_pm [4];
    logic [DW-1:0] r_pa [4];

    t_bcdw         r_x_sh   [N];
    logic [3:0]    r_x_q    [N];
    t_bcdw         r_x_sel  [N];
    logic [DW-1:0] r_x_a    [N];
    t_mults        r_x_m    [N];
    logic [DW-1:0] r_x_quot [N];

    t_bcdw         r_rem  [N];
    logic [DW-1:0] r_quot [N];
    logic [DW-1:0] r_ya   [N];
    t_mults        r_ym   [N];

    t_bcdw b_ext;
    assign b_ext = t_bcdw'(i_mb);

    always_comb begin
        n_pm[0]    = '0;
        n_pm[0][1] = b_ext;
        n_pm[0][2] = bcd_add(b_ext, b_ext, 1'b0);

        n_pm[1]    = r_pm[0];
        n_pm[1][3] = bcd_add(r_pm[0][2], r_pm[0][1], 1'b0);
        n_pm[1][4] = bcd_add(r_pm[0][2], r_pm[0][2], 1'b0);

        n_pm[2]    = r_pm[1];
        n_pm[2][5] = bcd_add(r_pm[1][4], r_pm[1][1], 1'b0);
        n_pm[2][6] = bcd_add(r_pm[1][4], r_pm[1][2], 1'b0);
        n_pm[2][7] = bcd_add(r_pm[1][4], r_pm[1][3], 1'b0);
        n_pm[2][8] = bcd_add(r_pm[1][4], r_pm[1][4], 1'b0);

        n_pm[3]    = r_pm[2];
        n_pm[3][9] = bcd_add(r_pm[2][8], r_pm[2][1], 1'b0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pa[0] <= i_ma;
            r_pa[1] <= r_pa[0];
            r_pa[2] <= r_pa[1];
            r_pa[3] <= r_pa[2];
            for (int k = 0; k < 4; k++) begin
                r_pm[k] <= n_pm[k];
            end
        end
    end

    for (genvar t = 0; t < N; t++) begin : g_digit
        t_bcdw         rem_in;
        logic [DW-1:0] a_in;
        t_mults        m_in;
        logic [DW-1:0] quot_in;
        t_bcdw         sh;
        logic [3:0]    q;

        if (t == 0) begin : g_first
            always_comb begin
                rem_in  = '0;
                a_in    = r_pa[3];
                m_in    = r_pm[3];
                quot_in = '0;
            end
        end else begin : g_next
            always_comb begin
                rem_in  = r_rem[t-1];
                a_in    = r_ya[t-1];
                m_in    = r_ym[t-1];
                quot_in = r_quot[t-1];
            end
        end

        always_comb begin
            sh = {rem_in[BW-5:0], a_in[4*(N-1-t) +: 4]};
            q  = 4'd0;
            for (int m = 1; m < 10; m++) begin
                q = q + {3'd0, (sh >= m_in[m])};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x_sh[t]   <= sh;
                r_x_q[t]    <= q;
                r_x_sel[t]  <= m_in[q];
                r_x_a[t]    <= a_in;
                r_x_m[t]    <= m_in;
                r_x_quot[t] <= quot_in;

                r_rem[t]  <= bcd_sub(r_x_sh[t], r_x_sel[t]);
                r_quot[t] <= {r_x_quot[t][DW-5:0], r_x_q[t]};
                r_ya[t]   <= r_x_a[t];
                r_ym[t]   <= r_x_m[t];
            end
        end
    end

    assign o_quot = r_quot[N-1];

endmodule

// File: src/bcd_sign_magnitude_alu_core.sv
// Signed packed-BCD arithmetic unit: add, subtract, multiply, divide, compare.
// Depends on bsmalu_pkg, bsmalu_mul and bsmalu_div.
//
// Input channel: i_valid / o_stall carry one t_in per transfer (command, two
// sign-magnitude BCD operands). Output channel: o_valid / i_stall carry one
// t_out per transfer (sign-magnitude result, overflow, divide-by-zero, signed
// compare flags). Digit nibbles above 9 read as 9; nibbles above NUM_DIGITS
// are ignored; a zero magnitude is always positive.
//
// Every command runs through the same pipeline, whose depth is set by the long
// divider, which spends two stages per quotient digit after four stages of
// divisor multiples. Throughput is one transfer per cycle whenever o_stall is
// low.
//
// Reset clears every valid bit; payload registers are not reset. While the
// output holds an untaken result and i_stall is high, the whole pipeline
// holds and o_stall is raised; no item is dropped or repeated.
module bcd_sign_magnitude_alu_core #(
    parameter int NUM_DIGITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  bsmalu_pkg::t_in   i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output bsmalu_pkg::t_out  o_data
);
    import bsmalu_pkg::*;

    localparam int DIV_LAT = 4 + 2*NUM_DIGITS;
    localparam int MUL_LAT = 2*NUM_DIGITS;
    localparam int MUL_PAD = DIV_LAT - MUL_LAT;
    localparam int SIDE_N  = DIV_LAT - 1;
    localparam t_bcdw LOW_MASK = (t_bcdw'(1) << (4*NUM_DIGITS)) - t_bcdw'(1);

    typedef struct packed {
        logic [1:0]    cmd;
        logic [DW-1:0] ma;
        logic [DW-1:0] mb;
        logic          na;
        logic          nb;
    } t_opnd;

    typedef struct packed {
        logic [1:0]    cmd;
        logic          na;
        logic          nb;
        logic          gt;
        logic          eq;
        logic          bz;
        logic [DW-1:0] x;
        logic [DW-1:0] y;
        logic          do_sub;
        logic          neg;
    } t_stage_a;

    typedef struct packed {
        logic [1:0]    cmd;
        logic          na;
        logic          nb;
        logic          gt;
        logic          eq;
        logic          bz;
        logic [DW-1:0] mag;
        logic          neg;
        logic          ovf;
    } t_side;

    typedef struct packed {
        logic [DW-1:0] mag;
        logic          ovf;
    } t_mres;

    logic             en;
    logic [DIV_LAT:0] r_vld;
    logic             r_out_vld;
    t_opnd            r_s0, n_s0;
    t_stage_a         r_sa, n_sa;
    t_side            r_side [SIDE_N];
    t_side            n_side;
    t_mres            r_mul_d [MUL_PAD];
    t_mres            mul_res;
    logic [DW-1:0]    div_q;
    t_out             r_out, n_out;

    assign o_stall = r_out_vld & i_stall;
    assign en      = ~o_stall;

    always_comb begin
        n_s0     = '0;
        n_s0.cmd = i_data.cmd;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            n_s0.ma[4*i +: 4] = (i_data.operand_a[4*i +: 4] > DIGIT_MAX)
                              ? DIGIT_MAX : i_data.operand_a[4*i +: 4];
            n_s0.mb[4*i +: 4] = (i_data.operand_b[4*i +: 4] > DIGIT_MAX)
                              ? DIGIT_MAX : i_data.operand_b[4*i +: 4];
        end
        n_s0.na = i_data.a_negative & (n_s0.ma != '0);
        n_s0.nb = i_data.b_negative & (n_s0.mb != '0);
    end

    always_comb begin
        logic eb;
        logic same;
        logic keep;
        eb          = (r_s0.cmd == CMD_SUB) ? ~r_s0.nb : r_s0.nb;
        same        = (r_s0.na == eb);
        keep        = same | (r_s0.ma >= r_s0.mb);
        n_sa.cmd    = r_s0.cmd;
        n_sa.na     = r_s0.na;
        n_sa.nb     = r_s0.nb;
        n_sa.bz     = (r_s0.mb == '0);
        n_sa.x      = keep ? r_s0.ma : r_s0.mb;
        n_sa.y      = keep ? r_s0.mb : r_s0.ma;
        n_sa.neg    = keep ? r_s0.na : eb;
        n_sa.do_sub = ~same;
        n_sa.eq     = (r_s0.na == r_s0.nb) && (r_s0.ma == r_s0.mb);
        if (r_s0.na != r_s0.nb) begin
            n_sa.gt = ~r_s0.na;
        end else if (!r_s0.na) begin
            n_sa.gt = r_s0.ma > r_s0.mb;
        end else begin
            n_sa.gt = r_s0.mb > r_s0.ma;
        end
    end

    always_comb begin
        t_bcdw sum;
        sum = r_sa.do_sub ? bcd_sub(t_bcdw'(r_sa.x), t_bcdw'(r_sa.y))
                          : bcd_add(t_bcdw'(r_sa.x), t_bcdw'(r_sa.y), 1'b0);
        n_side.cmd = r_sa.cmd;
        n_side.na  = r_sa.na;
        n_side.nb  = r_sa.nb;
        n_side.gt  = r_sa.gt;
        n_side.eq  = r_sa.eq;
        n_side.bz  = r_sa.bz;
        n_side.neg = r_sa.neg;
        n_side.mag = DW'(sum & LOW_MASK);
        n_side.ovf = ~r_sa.do_sub & (sum[4*NUM_DIGITS +: 4] != 4'd0);
    end

    bsmalu_mul #(.NUM_DIGITS(NUM_DIGITS)) u_mul (
        .i_clk (i_clk),
        .i_en  (en),
        .i_ma  (r_s0.ma),
        .i_mb  (r_s0.mb),
        .o_mag (mul_res.mag),
        .o_ovf (mul_res.ovf)
    );

    bsmalu_div #(.NUM_DIGITS(NUM_DIGITS)) u_div (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_ma   (r_s0.ma),
        .i_mb   (r_s0.mb),
        .o_quot (div_q)
    );

    always_comb begin
        t_side s;
        t_mres m;
        s     = r_side[SIDE_N-1];
        m     = r_mul_d[MUL_PAD-1];
        n_out = '0;
        n_out.a_greater = s.gt;
        n_out.a_equal   = s.eq;
        case (s.cmd) inside
            CMD_ADD, CMD_SUB: begin
                n_out.result_value    = s.mag;
                n_out.result_negative = s.neg;
                n_out.overflow        = s.ovf;
            end
            CMD_MUL: begin
                n_out.result_value    = m.mag;
                n_out.result_negative = s.na ^ s.nb;
                n_out.overflow        = m.ovf;
            end
            default: begin
                n_out.result_value    = s.bz ? '0 : div_q;
                n_out.result_negative = s.na ^ s.nb;
                n_out.divide_by_zero  = s.bz;
            end
        endcase
        if (n_out.result_value == '0) begin
            n_out.result_negative = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[DIV_LAT-1:0], i_valid};
            r_out_vld <= r_vld[DIV_LAT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0      <= n_s0;
            r_sa      <= n_sa;
            r_side[0] <= n_side;
            for (int k = 1; k < SIDE_N; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_mul_d[0] <= mul_res;
            for (int k = 1; k < MUL_PAD; k++) begin
                r_mul_d[k] <= r_mul_d[k-1];
            end
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.divide_by_zero |-> o_data.result_value == '0 && !o_data.overflow)
        else $error("divide by zero with nonzero result or overflow");

    a_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.result_value == '0 |-> !o_data.result_negative)
        else $error("negative zero result");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input held without a blocked output");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_data.a_greater && o_data.a_equal))
        else $error("greater and equal both set");

endmodule

// File: tb/bsmalu_checker.sv
// Result checker for the decimal ALU: predicts each result from the input transfers
// and compares it with the output transfers. Depends on bsmalu_pkg.
module bsmalu_checker #(
    parameter int NUM_DIGITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_in_stall,
    input  bsmalu_pkg::t_in  i_in_data,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  bsmalu_pkg::t_out i_out_data,
    output int               o_errors,
    output int               o_pending
);
    import bsmalu_pkg::*;

    t_out expected_q[$];
    int   mismatches = 0;

    function automatic logic [63:0] decode_bcd(logic [DW-1:0] bcd);
        logic [63:0] v;
        logic [3:0]  d;
        v = 0;
        for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
            d = bcd[4*i +: 4];
            if (d > DIGIT_MAX) d = DIGIT_MAX;
            v = v * 10 + 64'(d);
        end
        return v;
    endfunction

    function automatic logic [DW-1:0] encode_bcd(logic [63:0] v);
        logic [DW-1:0] r;
        r = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            r[4*i +: 4] = 4'(v % 10);
            v = v / 10;
        end
        return r;
    endfunction

    function automatic t_out compute_result(t_in x);
        t_out        r;
        logic [63:0] ma, mb, lim, mag;
        logic [127:0] prod;
        logic        na, nb, eb, neg, ovf, dz;
        ma  = decode_bcd(x.operand_a);
        mb  = decode_bcd(x.operand_b);
        na  = x.a_negative && ma != 0;
        nb  = x.b_negative && mb != 0;
        lim = 1;
        for (int i = 0; i < NUM_DIGITS; i++) lim = lim * 10;
        mag = 0; neg = 0; ovf = 0; dz = 0;
        case (x.cmd) inside
            CMD_ADD, CMD_SUB: begin
                eb = (x.cmd == CMD_SUB) ? !nb : nb;
                if (na == eb) begin
                    mag = ma + mb;
                    if (mag >= lim) begin
                        mag = mag - lim;
                        ovf = 1;
                    end
                    neg = na;
                end else if (ma >= mb) begin
                    mag = ma - mb;
                    neg = na;
                end else begin
                    mag = mb - ma;
                    neg = eb;
                end
            end
            CMD_MUL: begin
                prod = 128'(ma) * 128'(mb);
                ovf  = prod >= 128'(lim);
                mag  = 64'(prod % 128'(lim));
                neg  = na != nb;
            end
            default: begin
                if (mb == 0) begin
                    dz = 1;
                end else begin
                    mag = ma / mb;
                    neg = na != nb;
                end
            end
        endcase
        if (mag == 0) neg = 0;
        r.result_value    = encode_bcd(mag);
        r.result_negative = neg;
        r.overflow        = ovf;
        r.divide_by_zero  = dz;
        r.a_equal         = (na == nb) && (ma == mb);
        if (na != nb) r.a_greater = !na;
        else if (!na) r.a_greater = ma > mb;
        else          r.a_greater = mb > ma;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (i_valid && !i_in_stall) expected_q.push_back(compute_result(i_in_data));
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %p", i_out_data);
                end else begin
                    want = expected_q.pop_front();
                    if (want !== i_out_data) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", want, i_out_data);
                    end
                end
            end
        end
    end

    assign o_errors  = mismatches;
    assign o_pending = expected_q.size();
endmodule

// File: tb/tb_bcd_sign_magnitude_alu_core.sv
// Top of the decimal ALU regression: clock, reset, stimulus and verdict.
// Depends on bsmalu_pkg, bcd_sign_magnitude_alu_core and bsmalu_checker.
module tb_bcd_sign_magnitude_alu_core;
    import bsmalu_pkg::*;

    localparam int LATENCY = 6 + 2 * MAX_DIGITS;
    localparam int LIMIT   = 400000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic i_stall = 0;
    t_in  i_data = '0;
    logic o_stall, o_valid;
    t_out o_data;
    int   errors, pending;
    int   cycles = 0;
    int   sent = 0;

    always #5 i_clk = ~i_clk;

    bcd_sign_magnitude_alu_core #(.NUM_DIGITS(MAX_DIGITS)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    bsmalu_checker #(.NUM_DIGITS(MAX_DIGITS)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_in_stall(o_stall),
        .i_in_data(i_data), .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_out_data(o_data), .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("bcd_sign_magnitude_alu_core regression: fail");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        case ($urandom_range(0, 3))
            0:       i_stall <= ($urandom_range(0, 1) == 0);
            1:       i_stall <= 1'b0;
            default: i_stall <= i_stall;
        endcase
    end

    function automatic logic [DW-1:0] rand_bcd(int kind);
        logic [DW-1:0] v;
        int nd;
        v = '0;
        case (kind)
            0: v = {$urandom, $urandom};
            1: v = '0;
            2: begin
                nd = $urandom_range(1, MAX_DIGITS);
                for (int i = 0; i < nd; i++) v[4*i +: 4] = 4'($urandom_range(0, 9));
            end
            default: begin
                nd = $urandom_range(1, 4);
                for (int i = 0; i < nd; i++) v[4*i +: 4] = 4'($urandom_range(0, 9));
            end
        endcase
        return v;
    endfunction

    task automatic send(t_in x);
        @(negedge i_clk);
        i_data  <= x;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic send_pair(logic [1:0] c, logic [DW-1:0] a, logic sa,
                             logic [DW-1:0] b, logic sb);
        t_in x;
        x = '{cmd: c, operand_a: a, a_negative: sa, operand_b: b, b_negative: sb};
        send(x);
        sent++;
    endtask

    initial begin
        t_in x;
        int burst;
        logic [DW-1:0] nines, one;
        nines = {MAX_DIGITS{4'h9}};
        one   = 64'h1;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int c = 0; c < 4; c++) begin
            send_pair(2'(c), nines, 1'b0, nines, 1'b0);
            send_pair(2'(c), nines, 1'b1, one, 1'b0);
            send_pair(2'(c), '0, 1'b1, nines, 1'b1);
            send_pair(2'(c), {MAX_DIGITS{4'hF}}, 1'b0, 64'hA, 1'b1);
            send_pair(2'(c), 64'h123, 1'b1, '0, 1'b1);
            send_pair(2'(c), 64'h500, 1'b0, 64'h500, 1'b1);
        end
        drop_valid();
        while (pending != 0) @(posedge i_clk);

        while (sent < 1030) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst; k++) begin
                x.cmd        = 2'($urandom_range(0, 3));
                x.operand_a  = rand_bcd($urandom_range(0, 3));
                x.operand_b  = rand_bcd($urandom_range(0, 3));
                x.a_negative = 1'($urandom_range(0, 1));
                x.b_negative = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 9) == 0) x.operand_b = x.operand_a;
                send(x);
                sent++;
            end
            if ($urandom_range(0, 2) == 0) begin
                drop_valid();
                repeat ($urandom_range(1, 20)) @(negedge i_clk);
            end
        end
        drop_valid();

        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("covered %0d transfers: all commands, signed and zero operands,", sent);
        $display("non-decimal nibbles, overflow and divide by zero, with random stalls");
        if (errors == 0 && pending == 0) begin
            $display("bcd_sign_magnitude_alu_core regression: pass");
        end else begin
            $display("bcd_sign_magnitude_alu_core regression: fail");
        end
        $finish;
    end
endmodule
